>>> hw/rtl/cnpm_pkg.sv
// Shared types, constants and helpers for the CAN node presence monitor.
package cnpm_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 64;
   localparam int RES_CNT_W       = 7;

   localparam int KEY_W  = 17;
   localparam int VER_W  = 24;
   localparam int CRC_W  = 16;
   localparam int CNT_W  = 16;
   localparam int TYPE_W = 12;
   localparam int ID_W   = 29;
   localparam int REF_W  = 10;

   localparam logic [7:0]  TICKS_PER_SECOND_RST = 8'd10;
   localparam logic [7:0]  SWEEP_SECONDS_RST    = 8'd3;
   localparam logic [15:0] ANALOG_PERIOD_RST    = 16'(60 * 5);
   localparam logic [15:0] STATE_PERIOD_RST     = 16'(3600 * 6);

   localparam logic [REF_W-1:0]  REF_M        = 10'h14;
   localparam logic [REF_W-1:0]  REF_E        = 10'h15;
   localparam logic [TYPE_W-1:0] RQ_ANALOG    = 12'd258;
   localparam logic [TYPE_W-1:0] RQ_STATE_A   = 12'd267;
   localparam logic [TYPE_W-1:0] RQ_STATE_B   = 12'd268;
   localparam logic [TYPE_W-1:0] RQ_STATE_C   = 12'd269;
   localparam logic [TYPE_W-1:0] TYPE_HEARTBEAT = 12'd0;
   localparam logic [3:0]        HEARTBEAT_LEN  = 4'd5;

   typedef enum logic [1:0] {
      CSR_TICKS  = 2'd0,
      CSR_SWEEP  = 2'd1,
      CSR_ANALOG = 2'd2,
      CSR_STATE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_REQUEST = 2'd0,
      EV_LOST    = 2'd1,
      EV_FULL    = 2'd2
   } event_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HB_SCAN,
      ST_HB_TAIL,
      ST_HB_WRITE,
      ST_HB_EMIT,
      ST_HB_FULL,
      ST_SW_RD,
      ST_SW_PROC,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             alive;
      logic [VER_W-1:0] version;
      logic [CRC_W-1:0] crc;
      logic [CNT_W-1:0] count;
   } node_entry_type;

   typedef struct packed {
      logic            push;
      logic            finish;
      event_kind_type  kind;
      logic [ID_W-1:0] id;
   } emit_req_type;

   function automatic logic [TYPE_W-1:0] req_code(input logic [1:0] sel);
      logic [TYPE_W-1:0] code;
      case (sel)
         2'd0:    code = RQ_ANALOG;
         2'd1:    code = RQ_STATE_A;
         2'd2:    code = RQ_STATE_B;
         default: code = RQ_STATE_C;
      endcase
      return code;
   endfunction

   function automatic logic ref_hit(input logic [KEY_W-1:0] key);
      return (key[KEY_W-1:7] == REF_M) || (key[KEY_W-1:7] == REF_E);
   endfunction

endpackage

>>> hw/rtl/cnpm_tbl.sv
// Node table memory with per-entry valid bits and registered read data.
module cnpm_tbl #(
   parameter int DEPTH = cnpm_pkg::TABLE_DEPTH_DEF,
   parameter int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [IDXW-1:0]          rd_addr,
   output cnpm_pkg::node_entry_type rd_data,
   input  logic                     wr_en,
   input  logic [IDXW-1:0]          wr_addr,
   input  cnpm_pkg::node_entry_type wr_data
);

   cnpm_pkg::node_entry_type mem [DEPTH];
   cnpm_pkg::node_entry_type rd_q_ff;
   logic [DEPTH-1:0]         vld_ff;
   logic                     rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // never-written entries read as an empty slot
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

>>> hw/rtl/cnpm_emit.sv
// Result staging: one pending slot and the output register, marks the last item.
module cnpm_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  cnpm_pkg::emit_req_type        emit_req,
   output logic                          emit_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_event_kind,
   output logic [cnpm_pkg::ID_W-1:0]     rsp_frame_id,
   output logic                          rsp_last_of_run
);

   logic                         pend_vld_ff, pend_vld_in;
   cnpm_pkg::event_kind_type     pend_kind_ff, pend_kind_in;
   logic [cnpm_pkg::ID_W-1:0]    pend_id_ff, pend_id_in;
   logic                         out_vld_ff, out_vld_in;
   cnpm_pkg::event_kind_type     out_kind_ff, out_kind_in;
   logic [cnpm_pkg::ID_W-1:0]    out_id_ff, out_id_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_free;

   always_comb begin
      out_free    = !out_vld_ff || !rsp_stall;
      emit_ready  = !pend_vld_ff || out_free;
      pend_vld_in  = pend_vld_ff;
      pend_kind_in = pend_kind_ff;
      pend_id_in   = pend_id_ff;
      out_vld_in   = out_vld_ff;
      out_kind_in  = out_kind_ff;
      out_id_in    = out_id_ff;
      out_last_in  = out_last_ff;
      if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
      if (pend_vld_ff && out_free && (emit_req.push || emit_req.finish)) begin
         out_vld_in  = 1'b1;
         out_kind_in = pend_kind_ff;
         out_id_in   = pend_id_ff;
         out_last_in = emit_req.finish;
      end
      if (emit_req.push && emit_ready) begin
         pend_vld_in  = 1'b1;
         pend_kind_in = emit_req.kind;
         pend_id_in   = emit_req.id;
      end else if (emit_req.finish && emit_ready) begin
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      out_kind_ff  <= out_kind_in;
      out_id_ff    <= out_id_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_event_kind  = out_kind_ff;
   assign rsp_frame_id    = out_id_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

>>> hw/rtl/cnpm_ctrl.sv
// Sequencer: registers, second timers, table lookup/update and liveness sweep.
module cnpm_ctrl #(
   parameter int DEPTH = cnpm_pkg::TABLE_DEPTH_DEF,
   parameter int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_type,
   input  logic [28:0]               req_can_id,
   input  logic [3:0]                req_frame_length,
   input  logic [7:0]                req_version_high,
   input  logic [7:0]                req_version_mid,
   input  logic [7:0]                req_version_low,
   input  logic [7:0]                req_crc_high,
   input  logic [7:0]                req_crc_low,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   output cnpm_pkg::emit_req_type    emit_req,
   input  logic                      emit_ready,
   output logic                      tbl_rd_en,
   output logic [IDXW-1:0]           tbl_rd_addr,
   input  cnpm_pkg::node_entry_type  tbl_rd_data,
   output logic                      tbl_wr_en,
   output logic [IDXW-1:0]           tbl_wr_addr,
   output cnpm_pkg::node_entry_type  tbl_wr_data
);

   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DEPTH - 1);

   cnpm_pkg::ctrl_state_type state_ff, state_in;

   logic [7:0]  cfg_tps_ff, cfg_tps_in;
   logic [7:0]  cfg_sweep_ff, cfg_sweep_in;
   logic [15:0] cfg_analog_ff, cfg_analog_in;
   logic [15:0] cfg_state_ff, cfg_state_in;

   logic [7:0]  tick_count_ff, tick_count_in;
   logic [7:0]  sweep_sec_ff, sweep_sec_in;
   logic [15:0] analog_cd_ff, analog_cd_in;
   logic [15:0] state_cd_ff, state_cd_in;
   logic        analog_due_ff, analog_due_in;
   logic        state_due_ff, state_due_in;

   logic [IDXW-1:0] idx_ff, idx_in;
   logic [2:0]      step_ff, step_in;
   logic            cmp_vld_ff, cmp_vld_in;
   logic [IDXW-1:0] cmp_idx_ff, cmp_idx_in;
   logic            found_ff, found_in;
   logic [IDXW-1:0] found_idx_ff, found_idx_in;
   logic [cnpm_pkg::CNT_W-1:0] found_cnt_ff, found_cnt_in;
   logic            free_ff, free_in;
   logic [IDXW-1:0] free_idx_ff, free_idx_in;
   logic [cnpm_pkg::RES_CNT_W-1:0] out_cnt_ff, out_cnt_in;

   logic [cnpm_pkg::KEY_W-1:0] key_ff, key_in;
   logic [cnpm_pkg::VER_W-1:0] ver_ff, ver_in;
   logic [cnpm_pkg::CRC_W-1:0] crc_ff, crc_in;

   logic [7:0] tick_next;
   logic [7:0] sec_next;
   logic       capped;
   logic       occupied;
   logic       live;
   logic       hit;
   logic       want;
   logic       go;

   always_comb begin
      state_in      = state_ff;
      cfg_tps_in    = cfg_tps_ff;
      cfg_sweep_in  = cfg_sweep_ff;
      cfg_analog_in = cfg_analog_ff;
      cfg_state_in  = cfg_state_ff;
      tick_count_in = tick_count_ff;
      sweep_sec_in  = sweep_sec_ff;
      analog_cd_in  = analog_cd_ff;
      state_cd_in   = state_cd_ff;
      analog_due_in = analog_due_ff;
      state_due_in  = state_due_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_cnt_in  = found_cnt_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      out_cnt_in    = out_cnt_ff;
      key_in        = key_ff;
      ver_in        = ver_ff;
      crc_in        = crc_ff;

      req_stall   = (state_ff != cnpm_pkg::ST_IDLE);
      emit_req    = '0;
      tbl_rd_en   = 1'b0;
      tbl_rd_addr = idx_ff;
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = idx_ff;
      tbl_wr_data = tbl_rd_data;

      tick_next = tick_count_ff + 8'd1;
      sec_next  = sweep_sec_ff + 8'd1;
      capped    = (out_cnt_ff >= cnpm_pkg::RES_CNT_W'(cnpm_pkg::MAX_RESULTS));
      occupied  = (tbl_rd_data.key != '0);
      live      = occupied && tbl_rd_data.alive;
      hit       = live && cnpm_pkg::ref_hit(tbl_rd_data.key);
      want      = 1'b0;
      go        = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            cnpm_pkg::CSR_TICKS:  cfg_tps_in    = csr_wdata[7:0];
            cnpm_pkg::CSR_SWEEP:  cfg_sweep_in  = csr_wdata[7:0];
            cnpm_pkg::CSR_ANALOG: cfg_analog_in = csr_wdata;
            cnpm_pkg::CSR_STATE:  cfg_state_in  = csr_wdata;
            default: ;
         endcase
      end

      // lookup compare stage, in the cycle after the read address
      if (cmp_vld_ff) begin
         if (!found_ff && tbl_rd_data.key == key_ff) begin
            found_in     = 1'b1;
            found_idx_in = cmp_idx_ff;
            found_cnt_in = tbl_rd_data.count;
         end
         if (!free_ff && !occupied) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end

      unique case (state_ff)
         cnpm_pkg::ST_IDLE: begin
            out_cnt_in = '0;
            if (req_valid) begin
               if (req_type) begin
                  if (tick_next < cfg_tps_ff) begin
                     tick_count_in = tick_next;
                  end else begin
                     tick_count_in = '0;
                     if (analog_cd_ff <= 16'd1) begin
                        analog_cd_in  = cfg_analog_ff;
                        analog_due_in = 1'b1;
                     end else begin
                        analog_cd_in = analog_cd_ff - 16'd1;
                     end
                     if (state_cd_ff <= 16'd1) begin
                        state_cd_in  = cfg_state_ff;
                        state_due_in = 1'b1;
                     end else begin
                        state_cd_in = state_cd_ff - 16'd1;
                     end
                     if (sec_next >= cfg_sweep_ff) begin
                        sweep_sec_in = '0;
                        idx_in       = '0;
                        state_in     = cnpm_pkg::ST_SW_RD;
                     end else begin
                        sweep_sec_in = sec_next;
                     end
                  end
               end else if (req_can_id[28:17] == cnpm_pkg::TYPE_HEARTBEAT &&
                            req_frame_length == cnpm_pkg::HEARTBEAT_LEN &&
                            req_can_id[16:0] != '0) begin
                  key_in   = req_can_id[16:0];
                  ver_in   = {req_version_high, req_version_mid, req_version_low};
                  crc_in   = {req_crc_high, req_crc_low};
                  found_in = 1'b0;
                  free_in  = 1'b0;
                  idx_in   = '0;
                  state_in = cnpm_pkg::ST_HB_SCAN;
               end
            end
         end
         cnpm_pkg::ST_HB_SCAN: begin
            tbl_rd_en  = 1'b1;
            cmp_vld_in = 1'b1;
            cmp_idx_in = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = cnpm_pkg::ST_HB_TAIL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         cnpm_pkg::ST_HB_TAIL: begin
            state_in = cnpm_pkg::ST_HB_WRITE;
         end
         cnpm_pkg::ST_HB_WRITE: begin
            tbl_wr_data.key     = key_ff;
            tbl_wr_data.alive   = 1'b1;
            tbl_wr_data.version = ver_ff;
            tbl_wr_data.crc     = crc_ff;
            if (found_ff) begin
               tbl_wr_en         = 1'b1;
               tbl_wr_addr       = found_idx_ff;
               tbl_wr_data.count = (&found_cnt_ff) ? found_cnt_ff : found_cnt_ff + 1'b1;
               state_in          = cnpm_pkg::ST_FINISH;
            end else if (free_ff) begin
               tbl_wr_en         = 1'b1;
               tbl_wr_addr       = free_idx_ff;
               tbl_wr_data.count = '0;
               step_in           = '0;
               state_in          = cnpm_pkg::ref_hit(key_ff) ? cnpm_pkg::ST_HB_EMIT
                                                             : cnpm_pkg::ST_FINISH;
            end else begin
               state_in = cnpm_pkg::ST_HB_FULL;
            end
         end
         cnpm_pkg::ST_HB_EMIT: begin
            emit_req.push = !capped;
            emit_req.kind = cnpm_pkg::EV_REQUEST;
            emit_req.id   = {cnpm_pkg::req_code(step_ff[1:0]), key_ff};
            if (capped || emit_ready) begin
               if (step_ff == 3'd3) begin
                  state_in = cnpm_pkg::ST_FINISH;
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
         end
         cnpm_pkg::ST_HB_FULL: begin
            emit_req.push = !capped;
            emit_req.kind = cnpm_pkg::EV_FULL;
            emit_req.id   = {{cnpm_pkg::TYPE_W{1'b0}}, key_ff};
            if (capped || emit_ready) begin
               state_in = cnpm_pkg::ST_FINISH;
            end
         end
         cnpm_pkg::ST_SW_RD: begin
            tbl_rd_en = 1'b1;
            step_in   = '0;
            state_in  = cnpm_pkg::ST_SW_PROC;
         end
         cnpm_pkg::ST_SW_PROC: begin
            // steps: lost report, analog request, three state requests
            case (step_ff)
               3'd0: begin
                  want          = occupied && !tbl_rd_data.alive;
                  emit_req.kind = cnpm_pkg::EV_LOST;
                  emit_req.id   = {{cnpm_pkg::TYPE_W{1'b0}}, tbl_rd_data.key};
               end
               3'd1: begin
                  want          = hit && analog_due_ff;
                  emit_req.kind = cnpm_pkg::EV_REQUEST;
                  emit_req.id   = {cnpm_pkg::req_code(2'd0), tbl_rd_data.key};
               end
               default: begin
                  want          = hit && state_due_ff;
                  emit_req.kind = cnpm_pkg::EV_REQUEST;
                  emit_req.id   = {cnpm_pkg::req_code(2'(step_ff - 3'd1)), tbl_rd_data.key};
               end
            endcase
            emit_req.push = want && !capped;
            go            = !want || capped || emit_ready;
            if (go) begin
               if (step_ff == 3'd4) begin
                  tbl_wr_en         = live;
                  tbl_wr_addr       = idx_ff;
                  tbl_wr_data.alive = 1'b0;
                  if (idx_ff == LAST_IDX) begin
                     analog_due_in = 1'b0;
                     state_due_in  = 1'b0;
                     state_in      = cnpm_pkg::ST_FINISH;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = cnpm_pkg::ST_SW_RD;
                  end
               end else begin
                  step_in = step_ff + 3'd1;
               end
            end
         end
         cnpm_pkg::ST_FINISH: begin
            emit_req.finish = 1'b1;
            if (emit_ready) begin
               state_in = cnpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cnpm_pkg::ST_IDLE;
         end
      endcase

      if (emit_req.push && emit_ready) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cnpm_pkg::ST_IDLE;
         cfg_tps_ff    <= cnpm_pkg::TICKS_PER_SECOND_RST;
         cfg_sweep_ff  <= cnpm_pkg::SWEEP_SECONDS_RST;
         cfg_analog_ff <= cnpm_pkg::ANALOG_PERIOD_RST;
         cfg_state_ff  <= cnpm_pkg::STATE_PERIOD_RST;
         tick_count_ff <= '0;
         sweep_sec_ff  <= '0;
         analog_cd_ff  <= cnpm_pkg::ANALOG_PERIOD_RST;
         state_cd_ff   <= cnpm_pkg::STATE_PERIOD_RST;
         analog_due_ff <= 1'b0;
         state_due_ff  <= 1'b0;
         idx_ff        <= '0;
         step_ff       <= '0;
         cmp_vld_ff    <= 1'b0;
         found_ff      <= 1'b0;
         free_ff       <= 1'b0;
         out_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         cfg_tps_ff    <= cfg_tps_in;
         cfg_sweep_ff  <= cfg_sweep_in;
         cfg_analog_ff <= cfg_analog_in;
         cfg_state_ff  <= cfg_state_in;
         tick_count_ff <= tick_count_in;
         sweep_sec_ff  <= sweep_sec_in;
         analog_cd_ff  <= analog_cd_in;
         state_cd_ff   <= state_cd_in;
         analog_due_ff <= analog_due_in;
         state_due_ff  <= state_due_in;
         idx_ff        <= idx_in;
         step_ff       <= step_in;
         cmp_vld_ff    <= cmp_vld_in;
         found_ff      <= found_in;
         free_ff       <= free_in;
         out_cnt_ff    <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff   <= cmp_idx_in;
      found_idx_ff <= found_idx_in;
      found_cnt_ff <= found_cnt_in;
      free_idx_ff  <= free_idx_in;
      key_ff       <= key_in;
      ver_ff       <= ver_in;
      crc_ff       <= crc_in;
   end

endmodule

>>> hw/rtl/can_node_presence_monitor.sv
// Top level of the CAN node presence monitor.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_type, req_can_id, req_frame_length,
//                                             req_version_*, req_crc_*
//   rsp      out        rsp_valid/rsp_stall   rsp_event_kind, rsp_frame_id, rsp_last_of_run
//   csr      in         csr_write             csr_index, csr_wdata
//
// A tick that completes no sweep is handled within the idle state; a heartbeat walks
// the table memory before any of its results are emitted.
// A sweep handles each table entry with a read, then five result steps.
// The node table sits in one single-port-read memory; per-entry valid bits clear at
// reset, so there is no clearing pass.
// A stalled rsp holds the sequencer only when both result registers are full.
module can_node_presence_monitor #(
   parameter int TABLE_DEPTH = cnpm_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [28:0] req_can_id,
   input  logic [3:0]  req_frame_length,
   input  logic [7:0]  req_version_high,
   input  logic [7:0]  req_version_mid,
   input  logic [7:0]  req_version_low,
   input  logic [7:0]  req_crc_high,
   input  logic [7:0]  req_crc_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [28:0] rsp_frame_id,
   output logic        rsp_last_of_run,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   cnpm_pkg::emit_req_type   emit_req;
   logic                     emit_ready;
   logic                     tbl_rd_en;
   logic [IDXW-1:0]          tbl_rd_addr;
   cnpm_pkg::node_entry_type tbl_rd_data;
   logic                     tbl_wr_en;
   logic [IDXW-1:0]          tbl_wr_addr;
   cnpm_pkg::node_entry_type tbl_wr_data;

   cnpm_ctrl #(
      .DEPTH (TABLE_DEPTH),
      .IDXW  (IDXW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_can_id       (req_can_id),
      .req_frame_length (req_frame_length),
      .req_version_high (req_version_high),
      .req_version_mid  (req_version_mid),
      .req_version_low  (req_version_low),
      .req_crc_high     (req_crc_high),
      .req_crc_low      (req_crc_low),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .emit_req         (emit_req),
      .emit_ready       (emit_ready),
      .tbl_rd_en        (tbl_rd_en),
      .tbl_rd_addr      (tbl_rd_addr),
      .tbl_rd_data      (tbl_rd_data),
      .tbl_wr_en        (tbl_wr_en),
      .tbl_wr_addr      (tbl_wr_addr),
      .tbl_wr_data      (tbl_wr_data)
   );

   cnpm_tbl #(
      .DEPTH (TABLE_DEPTH),
      .IDXW  (IDXW)
   ) u_tbl (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data)
   );

   cnpm_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .emit_req        (emit_req),
      .emit_ready      (emit_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_frame_id    (rsp_frame_id),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> hw/rtl/cnpm_checker.sv
// Port-level checks for the CAN node presence monitor, bound to the top level.
module cnpm_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_type,
   input logic [28:0] req_can_id,
   input logic [3:0]  req_frame_length,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_event_kind,
   input logic [28:0] rsp_frame_id,
   input logic        rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind) &&
      $stable(rsp_frame_id) && $stable(rsp_last_of_run))
      else $error("rsp item changed while stalled");

   a_rsp_id_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind == cnpm_pkg::EV_REQUEST) ?
         (rsp_frame_id[28:17] == cnpm_pkg::RQ_ANALOG ||
          rsp_frame_id[28:17] == cnpm_pkg::RQ_STATE_A ||
          rsp_frame_id[28:17] == cnpm_pkg::RQ_STATE_B ||
          rsp_frame_id[28:17] == cnpm_pkg::RQ_STATE_C) :
         (rsp_frame_id[28:17] == cnpm_pkg::TYPE_HEARTBEAT))
      else $error("rsp frame id type does not match event kind");

   a_rsp_key_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_id[16:0] != '0)
      else $error("rsp item carries an empty node key");

   a_hb_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_type &&
      req_can_id[28:17] == cnpm_pkg::TYPE_HEARTBEAT &&
      req_frame_length == cnpm_pkg::HEARTBEAT_LEN && req_can_id[16:0] != '0
      |=> req_stall)
      else $error("heartbeat accepted without table lookup");

endmodule

bind can_node_presence_monitor cnpm_port_checks u_cnpm_port_checks (.*);
